### hdl/masked_byte_pattern_scan_macros.svh
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_macros
// Assertion macros used by the scanner top level.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCAN_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCAN_MACROS_SVH

`ifndef ASSERT_OFF
`define MBPS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mbps assertion failed");
`define MBPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mbps assertion failed");
`else
`define MBPS_ASSERT(lbl, clk, rst, prop)
`define MBPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### hdl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Constants and types of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int PAT_BYTES   = 32;
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W       = 7;
  localparam int ADDR_W      = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_ALL = 3'd6;

  typedef struct packed {
    logic [PAT_BYTES*8-1:0] pattern;
    logic [PAT_BYTES-1:0]   care;
    logic [5:0]             length;
    logic                   report_all;
  } mbps_cfg_t;

  typedef struct packed {
    logic       accept;
    logic       live;
    logic [7:0] data;
  } mbps_shift_t;

endpackage

### hdl/mbps_ifs.sv
// ----------------------------------------------------------------------------
// mbps_ifs
// Handshake channels of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
interface mbps_in_if;
  logic                             valid;
  logic                             ready;
  logic [7:0]                       data_byte;
  logic [mbps_pkg::ADDR_W-1:0]      byte_address;
  logic                             region_start;
  logic                             scan_start;

  modport source (output valid, data_byte, byte_address, region_start, scan_start,
                  input ready);
  modport sink   (input valid, data_byte, byte_address, region_start, scan_start,
                  output ready);
endinterface

interface mbps_out_if;
  logic                        valid;
  logic                        ready;
  logic [mbps_pkg::ADDR_W-1:0] match_address;

  modport source (output valid, match_address, input ready);
  modport sink   (input valid, match_address, output ready);
endinterface

interface mbps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mbps_pkg::CFG_IDX_W-1:0]  index;
  logic [mbps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/mbps_cfg_regs.sv
// ----------------------------------------------------------------------------
// mbps_cfg_regs
// Configuration register file: pattern bytes, care mask, length, mode.
// ----------------------------------------------------------------------------
module mbps_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  mbps_cfg_if.sink            cfg,
  output mbps_pkg::mbps_cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pattern    <= '0;
      regs.care       <= '0;
      regs.length     <= 6'd1;
      regs.report_all <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        mbps_pkg::REG_PATTERN_0:  regs.pattern[63:0]    <= cfg.data;
        mbps_pkg::REG_PATTERN_1:  regs.pattern[127:64]  <= cfg.data;
        mbps_pkg::REG_PATTERN_2:  regs.pattern[191:128] <= cfg.data;
        mbps_pkg::REG_PATTERN_3:  regs.pattern[255:192] <= cfg.data;
        mbps_pkg::REG_CARE_MASK:  regs.care             <= cfg.data[31:0];
        mbps_pkg::REG_LENGTH:     regs.length           <= cfg.data[5:0];
        mbps_pkg::REG_REPORT_ALL: regs.report_all       <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell
// One history position: holds a byte of the current region, hands it to its
// right neighbor on each word and extends the match chain with its compare.
// ----------------------------------------------------------------------------
module mbps_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  mbps_pkg::mbps_shift_t shift,
  input  logic                  clear,
  input  logic [7:0]            pat,
  input  logic                  care,
  input  logic                  used,
  input  logic                  link_in,
  output logic                  link_out,
  output logic [7:0]            data,
  output logic                  live
);

  logic [7:0] held_byte;
  logic       held_live;
  logic       ok;

  // region start drops every held byte before this word
  assign live     = held_live & ~clear;
  assign data     = held_byte;
  assign ok       = ~used | (live & (~care | (held_byte == pat)));
  assign link_out = link_in & ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte <= 8'h00;
      held_live <= 1'b0;
    end else if (shift.accept) begin
      held_byte <= shift.data;
      held_live <= shift.live;
    end
  end

endmodule

### hdl/masked_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan
// Latency: a match address is valid the cycle after its last byte is taken.
// Throughput: one byte per cycle; all cells advance together on each word.
// The output register stalls input only while it holds an untaken word.
// Reset (synchronous): clears byte history, found latch and output valid;
// configuration returns to length 1, empty mask, first-match mode.
// ----------------------------------------------------------------------------
`include "masked_byte_pattern_scan_macros.svh"

module masked_byte_pattern_scan (
  input  logic       clk,
  input  logic       rst,
  mbps_cfg_if.sink   cfg,
  mbps_in_if.sink    bytes,
  mbps_out_if.source results
);

  localparam int MAXP  = mbps_pkg::MAX_PATTERN;
  localparam int IDX_W = mbps_pkg::IDX_W;
  localparam int LEN_W = mbps_pkg::LEN_W;

  mbps_pkg::mbps_cfg_t           regs;
  logic [7:0]                    hist [MAXP];
  logic [MAXP-1:0]               lives;
  logic [MAXP-1:0]               links;
  logic [7:0]                    apat [MAXP];
  logic [MAXP-1:0]               acare;
  logic [MAXP-1:0]               used;
  logic [LEN_W-1:0]              len_m1;
  logic                          accept;
  logic                          hit_sel;
  logic                          found_eff;
  logic                          report;
  logic                          first_found;
  logic                          out_valid;
  logic [mbps_pkg::ADDR_W-1:0]   out_addr;

  mbps_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign bytes.ready  = ~out_valid | results.ready;
  assign accept       = bytes.valid & bytes.ready;

  always_comb begin
    if (regs.length == 6'd0) begin
      len_m1 = '0;
    end else if ({1'b0, regs.length} > LEN_W'(MAXP)) begin
      len_m1 = LEN_W'(MAXP - 1);
    end else begin
      len_m1 = {1'b0, regs.length} - LEN_W'(1);
    end
  end

  // pattern byte and care bit that line up with the byte of age k
  always_comb begin
    logic [IDX_W-1:0] pos;
    for (int k = 0; k < MAXP; k++) begin
      pos      = len_m1[IDX_W-1:0] - IDX_W'(k);
      apat[k]  = regs.pattern[{pos, 3'b000} +: 8];
      acare[k] = regs.care[pos];
      used[k]  = (LEN_W'(k) <= len_m1);
    end
  end

  // age 0 is the incoming word itself
  assign hist[0]  = bytes.data_byte;
  assign lives[0] = 1'b1;
  assign links[0] = ~acare[0] | (bytes.data_byte == apat[0]);

  for (genvar k = 1; k < MAXP; k++) begin : g_cell
    mbps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    ({accept, lives[k-1], hist[k-1]}),
      .clear    (bytes.region_start),
      .pat      (apat[k]),
      .care     (acare[k]),
      .used     (used[k]),
      .link_in  (links[k-1]),
      .link_out (links[k]),
      .data     (hist[k]),
      .live     (lives[k])
    );
  end

  assign hit_sel   = links[MAXP-1];
  assign found_eff = first_found & ~bytes.scan_start;
  assign report    = hit_sel & (regs.report_all | ~found_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_found <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        first_found <= found_eff | hit_sel;
        out_valid   <= report;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && report) begin
      out_addr <= bytes.byte_address
                  - {{(mbps_pkg::ADDR_W - LEN_W){1'b0}}, len_m1};
    end
  end

  assign results.valid         = out_valid;
  assign results.match_address = out_addr;

  `MBPS_ASSERT(a_valid_found, clk, rst, out_valid |-> first_found)
  `MBPS_ASSERT(a_report_loads, clk, rst, (accept && report) |=> out_valid)
  `MBPS_ASSERT(a_region_clears, clk, rst, (accept && bytes.region_start) |=> (lives[MAXP-1:2] == '0))
  `MBPS_ASSERT(a_out_hold, clk, rst, (out_valid && !results.ready) |=> (out_valid && $stable(out_addr)))

endmodule
